// ----- rtl/imu_sfp_pkg.sv -----
// Shared types and constants for the IMU serial frame parser.
// No dependencies; every other file in rtl/ imports this package.
package imu_sfp_pkg;

  // Framing bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Payload bytes that carry the three little-endian axis words
  localparam int unsigned AXIS_BYTES = 6;

  // Parse phase: waiting, or a frame of one kind is open
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_ACC   = 2'd1,
    PH_RATE  = 2'd2,
    PH_ANGLE = 2'd3
  } imu_sfp_phase_e;

  // One decoded frame
  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } imu_sfp_res_t;

  // Status of the input register stage towards the rest of the block
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } imu_sfp_beat_t;

endpackage

// ----- rtl/imu_sfp_in_reg.sv -----
// Input register stage of the IMU serial frame parser.
// Depends on imu_sfp_pkg.
module imu_sfp_in_reg import imu_sfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          adv_i,
  output imu_sfp_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = rx_byte_i;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

// ----- rtl/imu_sfp_parser.sv -----
// Frame state machine, checksum and axis byte store of the IMU frame parser.
// Depends on imu_sfp_pkg.
module imu_sfp_parser import imu_sfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         res_valid_o,
  output imu_sfp_res_t res_o
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_AXIS = CNT_W'(AXIS_BYTES);

  imu_sfp_phase_e   phase_q, phase_d;
  logic [7:0]       prior_q, prior_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       axis_q [AXIS_BYTES];
  logic             axis_we;
  logic             is_type;

  assign is_type = (byte_i >= TYPE_ACC) && (byte_i <= TYPE_ANGLE);

  always_comb begin
    phase_d     = phase_q;
    prior_d     = prior_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    axis_we     = 1'b0;
    res_valid_o = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        if (is_type) begin
          if (prior_q == HDR_BYTE) begin
            phase_d = imu_sfp_phase_e'(byte_i[1:0] - TYPE_ACC[1:0] + 2'd1);
            cnt_d   = '0;
            sum_d   = HDR_BYTE + byte_i;
          end
        end else begin
          prior_d = byte_i;
        end
      end
      PH_ACC, PH_RATE, PH_ANGLE: begin
        if (cnt_q < CNT_FULL) begin
          axis_we = (cnt_q < CNT_AXIS);
          cnt_d   = cnt_q + CNT_W'(1);
          sum_d   = sum_q + byte_i;
        end else begin
          // checksum beat: close the frame whatever the outcome
          res_valid_o = (byte_i == sum_q);
          phase_d     = PH_WAIT;
          prior_d     = '0;
          cnt_d       = '0;
          sum_d       = '0;
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      prior_q <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prior_q <= prior_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && axis_we) begin
      axis_q[cnt_q[2:0]] <= byte_i;
    end
  end

  assign res_o.kind = 2'(phase_q) - 2'd1;
  assign res_o.x    = {axis_q[1], axis_q[0]};
  assign res_o.y    = {axis_q[3], axis_q[2]};
  assign res_o.z    = {axis_q[5], axis_q[4]};

endmodule

// ----- rtl/imu_sfp_out_reg.sv -----
// Result register of the IMU serial frame parser.
// Depends on imu_sfp_pkg.
module imu_sfp_out_reg import imu_sfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  imu_sfp_res_t res_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic         free_o,
  output imu_sfp_res_t res_o
);

  logic         valid_q, valid_d;
  imu_sfp_res_t res_q, res_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/imu_serial_frame_parser_unit.sv -----
// IMU serial frame parser: one received byte per beat, one frame result per good frame.
// Path: checksum byte held in the input register, its result then in the result register.
// Throughput: one byte per cycle unless stalled; the parse step is combinational.
// Back-pressure on the result side stalls the input stage only when a result is waiting.
// Reset (rst_ni low, asynchronous): parser waits for a header, prior byte and sum cleared.
// Depends on imu_sfp_pkg, imu_sfp_in_reg, imu_sfp_parser, imu_sfp_out_reg.
module imu_serial_frame_parser_unit import imu_sfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         frame_kind_o,
  output logic signed [15:0] value_x_o,
  output logic signed [15:0] value_y_o,
  output logic signed [15:0] value_z_o
);

  imu_sfp_beat_t beat;
  imu_sfp_res_t  res, res_held;
  logic          res_valid;
  logic          out_free;
  logic          adv;
  logic          res_load;

  // Advance the held byte unless it closes a good frame and the result
  // register is still occupied; bytes that produce nothing never stall.
  assign adv      = beat.valid && (!res_valid || out_free);
  assign res_load = adv && res_valid;

  // Input register: hold one beat from the serial side
  imu_sfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .beat_o     (beat)
  );

  // Parse step: framing, checksum and axis bytes
  imu_sfp_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .byte_i      (beat.data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: parts the parse step from the consumer
  imu_sfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_held)
  );

  assign frame_kind_o = res_held.kind;
  assign value_x_o    = res_held.x;
  assign value_y_o    = res_held.y;
  assign value_z_o    = res_held.z;

  // A result is loaded only into a free result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // A stalled input beat keeps its byte until it advances
  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat.valid && !adv) |=> (beat.valid && $stable(beat.data)))
    else $error("input beat lost while stalled");

  // An empty input register always takes a new byte
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !beat.valid |-> in_ready_o)
    else $error("input stalled while empty");

  // A delivered frame never carries the unused kind code
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_kind_o != 2'd3))
    else $error("bad frame kind");

endmodule
